// ===== src/slpl_pkg.sv =====
// Shared constants, codes and types of the steering position linearizer.
package slpl_pkg;

   localparam int WINDOW       = 10;
   localparam int PTR_W        = $clog2(WINDOW);
   localparam int ADC_W        = 12;
   localparam int OUT_W        = 16;
   localparam int SUM_W        = ADC_W + $clog2(WINDOW);
   localparam int RECIP_SHIFT  = 20;
   localparam int RECIP        = (1 << RECIP_SHIFT) / WINDOW;
   localparam int AVG_PROD_W   = SUM_W + RECIP_SHIFT;
   localparam int DIFF_W       = ADC_W + 1;
   localparam int SPAN_W       = OUT_W + 2;
   localparam int PROD_W       = DIFF_W + SPAN_W;
   localparam int MAG_W        = 28;
   localparam int CNT_W        = $clog2(MAG_W);
   localparam int VAL_W        = 32;

   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 32;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [ADC_W-1:0]        ADC_MAX_COUNT   = '1;
   localparam logic [ADC_W-1:0]        LEFT_CAL_RST    = 12'd4095;
   localparam logic [ADC_W-1:0]        MIDDLE_CAL_RST  = 12'd2047;
   localparam logic [ADC_W-1:0]        RIGHT_CAL_RST   = 12'd0;
   localparam logic signed [OUT_W-1:0] OUT_MIN_RST     = 16'sd0;
   localparam logic signed [OUT_W-1:0] OUT_MID_RST     = 16'sd512;
   localparam logic signed [OUT_W-1:0] OUT_MAX_RST     = 16'sd1023;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEFT_CAL   = 3'd0,
      CSR_MIDDLE_CAL = 3'd1,
      CSR_RIGHT_CAL  = 3'd2,
      CSR_OUT_MIN    = 3'd3,
      CSR_OUT_MID    = 3'd4,
      CSR_OUT_MAX    = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG_MUL,
      ST_AVG_FIX,
      ST_SETUP,
      ST_MAP_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic avg_mul;
      logic avg_fix;
      logic setup;
      logic map_mul;
      logic div_load;
      logic div_step;
      logic sum;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== src/slpl_ctrl.sv =====
// Sequencer that steps one sample through the averaging and mapping datapath.
module slpl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  slpl_pkg::status_type status,
   output slpl_pkg::cmd_type    cmd
);

   slpl_pkg::state_type              state_ff, state_in;
   logic [slpl_pkg::CNT_W-1:0]       cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slpl_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         slpl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = slpl_pkg::ST_AVG_MUL;
            end
         end
         slpl_pkg::ST_AVG_MUL: begin
            cmd.avg_mul = 1'b1;
            state_in    = slpl_pkg::ST_AVG_FIX;
         end
         slpl_pkg::ST_AVG_FIX: begin
            cmd.avg_fix = 1'b1;
            state_in    = slpl_pkg::ST_SETUP;
         end
         slpl_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = slpl_pkg::ST_MAP_MUL;
         end
         slpl_pkg::ST_MAP_MUL: begin
            cmd.map_mul = 1'b1;
            state_in    = slpl_pkg::ST_DIV_LOAD;
         end
         slpl_pkg::ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = slpl_pkg::ST_DIV;
         end
         slpl_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == slpl_pkg::CNT_W'(slpl_pkg::MAG_W - 1)) begin
               state_in = slpl_pkg::ST_SUM;
            end
         end
         slpl_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = slpl_pkg::ST_DONE;
         end
         slpl_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = slpl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slpl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/slpl_dp.sv =====
// Datapath: sample ring, running sum, average, calibration map, divider, output register.
module slpl_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [slpl_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slpl_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [slpl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [slpl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  slpl_pkg::cmd_type                   cmd,
   output slpl_pkg::status_type                status
);

   localparam int ADC_W  = slpl_pkg::ADC_W;
   localparam int OUT_W  = slpl_pkg::OUT_W;
   localparam int SUM_W  = slpl_pkg::SUM_W;
   localparam int PTR_W  = slpl_pkg::PTR_W;
   localparam int DIFF_W = slpl_pkg::DIFF_W;
   localparam int SPAN_W = slpl_pkg::SPAN_W;
   localparam int PROD_W = slpl_pkg::PROD_W;
   localparam int MAG_W  = slpl_pkg::MAG_W;
   localparam int VAL_W  = slpl_pkg::VAL_W;

   // configuration
   logic [ADC_W-1:0]        left_ff, middle_ff, right_ff;
   logic signed [OUT_W-1:0] out_min_ff, out_mid_ff, out_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= slpl_pkg::LEFT_CAL_RST;
         middle_ff  <= slpl_pkg::MIDDLE_CAL_RST;
         right_ff   <= slpl_pkg::RIGHT_CAL_RST;
         out_min_ff <= slpl_pkg::OUT_MIN_RST;
         out_mid_ff <= slpl_pkg::OUT_MID_RST;
         out_max_ff <= slpl_pkg::OUT_MAX_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            slpl_pkg::CSR_LEFT_CAL:   left_ff    <= csr_wdata[ADC_W-1:0];
            slpl_pkg::CSR_MIDDLE_CAL: middle_ff  <= csr_wdata[ADC_W-1:0];
            slpl_pkg::CSR_RIGHT_CAL:  right_ff   <= csr_wdata[ADC_W-1:0];
            slpl_pkg::CSR_OUT_MIN:    out_min_ff <= $signed(csr_wdata[OUT_W-1:0]);
            slpl_pkg::CSR_OUT_MID:    out_mid_ff <= $signed(csr_wdata[OUT_W-1:0]);
            slpl_pkg::CSR_OUT_MAX:    out_max_ff <= $signed(csr_wdata[OUT_W-1:0]);
            default: ;
         endcase
      end
   end

   // sample ring and running sum
   logic [ADC_W-1:0] ring_ff [slpl_pkg::WINDOW];
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [ADC_W-1:0] sample;

   assign sample = req_tdata[ADC_W-1:0];
   assign ptr_in = (ptr_ff == PTR_W'(slpl_pkg::WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
   assign sum_in = sum_ff - SUM_W'(ring_ff[ptr_in]) + SUM_W'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < slpl_pkg::WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
         ptr_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.accept) begin
         ring_ff[ptr_in] <= sample;
         ptr_ff          <= ptr_in;
         sum_ff          <= sum_in;
      end
   end

   // average: reciprocal multiply, then one correction step and clamp
   logic [slpl_pkg::AVG_PROD_W-1:0] avg_prod_ff;
   logic [SUM_W-1:0]                q_est, q_times_w, q_rem, q_fix;
   logic [ADC_W-1:0]                avg_ff, avg_in;

   assign q_est     = avg_prod_ff[slpl_pkg::AVG_PROD_W-1:slpl_pkg::RECIP_SHIFT];
   assign q_times_w = SUM_W'(q_est * SUM_W'(slpl_pkg::WINDOW));
   assign q_rem     = sum_ff - q_times_w;
   assign q_fix     = (q_rem >= SUM_W'(slpl_pkg::WINDOW)) ? q_est + 1'b1 : q_est;
   assign avg_in    = (q_fix > SUM_W'(slpl_pkg::ADC_MAX_COUNT)) ?
                      slpl_pkg::ADC_MAX_COUNT : q_fix[ADC_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.avg_mul) begin
         avg_prod_ff <= slpl_pkg::AVG_PROD_W'(sum_ff) *
                        slpl_pkg::AVG_PROD_W'(slpl_pkg::RECIP);
      end
      if (cmd.avg_fix) begin
         avg_ff <= avg_in;
      end
   end

   // segment selection
   logic                     asc, desc, left_side;
   logic [ADC_W-1:0]         f_lo, f_hi;
   logic signed [SPAN_W-1:0] t_lo_x, t_hi_x;
   logic signed [OUT_W-1:0]  t_lo;
   logic signed [DIFF_W-1:0] diff_ff, den_ff;
   logic signed [SPAN_W-1:0] span_ff;
   logic signed [OUT_W-1:0]  tlo_ff;
   logic                     mapped_ff;

   assign asc       = (left_ff < middle_ff) && (middle_ff < right_ff);
   assign desc      = (left_ff > middle_ff) && (middle_ff > right_ff);
   assign left_side = asc ? (avg_ff < middle_ff) : (avg_ff > middle_ff);

   always_comb begin
      if (left_side) begin
         f_lo   = left_ff;
         f_hi   = middle_ff;
         t_lo   = out_min_ff;
         t_hi_x = SPAN_W'(out_mid_ff) - 18'sd1;
      end else begin
         f_lo   = middle_ff;
         f_hi   = right_ff;
         t_lo   = out_mid_ff;
         t_hi_x = SPAN_W'(out_max_ff);
      end
      t_lo_x = SPAN_W'(t_lo);
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         diff_ff   <= $signed({1'b0, avg_ff}) - $signed({1'b0, f_lo});
         den_ff    <= $signed({1'b0, f_hi}) - $signed({1'b0, f_lo});
         span_ff   <= t_hi_x - t_lo_x;
         tlo_ff    <= t_lo;
         mapped_ff <= asc || desc;
      end
   end

   // product and restoring divider on magnitudes
   logic signed [PROD_W-1:0] prod_ff, prod_neg;
   logic [PROD_W-1:0]        prod_mag;
   logic signed [DIFF_W-1:0] den_neg;
   logic [DIFF_W-1:0]        den_mag;
   logic                     neg_ff;
   logic [ADC_W-1:0]         divisor_ff, rem_ff, rem_in;
   logic [MAG_W-1:0]         quo_ff;
   logic [ADC_W:0]           trial, trial_sub;
   logic                     trial_ge;

   assign prod_neg  = -prod_ff;
   assign prod_mag  = prod_ff[PROD_W-1] ? prod_neg : prod_ff;
   assign den_neg   = -den_ff;
   assign den_mag   = den_ff[DIFF_W-1] ? den_neg : den_ff;
   assign trial     = {rem_ff, quo_ff[MAG_W-1]};
   assign trial_ge  = trial >= {1'b0, divisor_ff};
   assign trial_sub = trial - {1'b0, divisor_ff};
   assign rem_in    = trial_ge ? trial_sub[ADC_W-1:0] : trial[ADC_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.map_mul) begin
         prod_ff <= PROD_W'(diff_ff) * PROD_W'(span_ff);
      end
      if (cmd.div_load) begin
         neg_ff     <= prod_ff[PROD_W-1] ^ den_ff[DIFF_W-1];
         quo_ff     <= prod_mag[MAG_W-1:0];
         divisor_ff <= den_mag[ADC_W-1:0];
         rem_ff     <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[MAG_W-2:0], trial_ge};
         rem_ff <= rem_in;
      end
   end

   // offset, clamp and output register
   logic signed [VAL_W-1:0] quo_x, quo_s, val_ff, val_in, min_x, max_x;
   logic signed [OUT_W-1:0] pos;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADC_W-1:0]        rsp_avg_ff;
   logic signed [OUT_W-1:0] rsp_pos_ff;

   assign quo_x  = $signed(VAL_W'(quo_ff));
   assign quo_s  = neg_ff ? -quo_x : quo_x;
   assign val_in = mapped_ff ? quo_s + VAL_W'(tlo_ff) : $signed(VAL_W'(avg_ff));
   assign min_x  = VAL_W'(out_min_ff);
   assign max_x  = VAL_W'(out_max_ff);
   assign pos    = (val_ff < min_x) ? out_min_ff :
                   (val_ff > max_x) ? out_max_ff : val_ff[OUT_W-1:0];

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in    = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         val_ff <= val_in;
      end
      if (cmd.out_load) begin
         rsp_avg_ff <= avg_ff;
         rsp_pos_ff <= pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(slpl_pkg::RSP_TDATA_W - ADC_W - OUT_W)'(0), rsp_pos_ff, rsp_avg_ff};

endmodule

// ===== src/steering_position_linearizer_top.sv =====
// Top level of the steering position linearizer: controller plus datapath.
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready  req_tdata[11:0]  sample
//  rsp_     out  rsp_tvalid/rsp_tready  rsp_tdata[11:0]  averaged, [27:12] position
//  csr_     in   csr_we                 csr_index, csr_wdata
//
// One sample is worked on at a time: the block takes no new sample until the result
// of the last has entered the output register. The 28-step restoring divider of the
// calibration map does most of the work on each sample.
// Synchronous reset clears the sample ring, running sum and pointer and loads the
// default calibration. A stalled result holds in the output register while the
// next sample is taken and worked on; that sample then waits until the slot is free.
module steering_position_linearizer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [slpl_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [11:0] sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slpl_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // [11:0] averaged, [27:12] position
   input  logic                                csr_we,
   input  logic [slpl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [slpl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   slpl_pkg::cmd_type    cmd;
   slpl_pkg::status_type status;

   slpl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   slpl_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while a sample is in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output register loaded while a result is pending");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("loaded result not presented");

endmodule
